@@ rtl/sre_pkg.sv @@
// Shared types and constants for the sequenced event ring.
// Holds the field widths and the layout of one stored ring entry.
// No dependencies.
package sre_pkg;

  localparam int SEQ_W  = 64;
  localparam int TIME_W = 32;
  localparam int LEN_W  = 4;
  localparam int PAY_W  = 64;
  localparam int RAW_LEN_W = 8;
  localparam int COUNT_W = 5;

  // Most events that one read returns
  localparam logic [COUNT_W-1:0] MOST_RESULTS = 5'd16;

  // Request codes
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef struct packed {
    logic [SEQ_W-1:0]  seq;
    logic [TIME_W-1:0] stamp;
    logic [LEN_W-1:0]  len;
    logic [PAY_W-1:0]  pay;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

@@ rtl/sequenced_event_ring.sv @@
// Sequenced event ring: overwriting circular trace buffer with 64-bit sequence tags.
// Depends on sre_pkg (entry layout, widths, op codes) and sre_ram (entry storage).
//
//   channel  dir  handshake            fields
//   request  in   req_valid/req_ready  op payload payload_length timestamp_ms
//                                      start_sequence max_count
//   result   out  rsp_valid/rsp_ready  valid_res event_sequence event_time
//                                      event_length event_payload last
//
// A push is written into the ring RAM in the cycle it is accepted, and the next
// request can be taken in the following cycle.
// After acceptance a read clamps the start, then finds the first slot and the
// count; it then issues one RAM read per event, and each event moves from the RAM
// read register into the output register once the result side is free. A read of
// n events (n at most 16) holds the request side until its walk is done, an empty
// read until its marker is loaded. The walk stalls while the result side holds off
// a waiting result. The final result may still wait in the output register while
// the next request is accepted. rst is synchronous; no clearing pass, since a read
// never reaches a slot that was never pushed.
module sequenced_event_ring
  import sre_pkg::*;
#(
  parameter int RING_DEPTH    = 16,
  parameter int PAYLOAD_BYTES = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  logic                 op,
  input  logic [PAY_W-1:0]     payload,
  input  logic [RAW_LEN_W-1:0] payload_length,
  input  logic [TIME_W-1:0]    timestamp_ms,
  input  logic [SEQ_W-1:0]     start_sequence,
  input  logic [COUNT_W-1:0]   max_count,
  output logic                 rsp_valid,
  input  logic                 rsp_ready,
  output logic                 valid_res,
  output logic [SEQ_W-1:0]     event_sequence,
  output logic [TIME_W-1:0]    event_time,
  output logic [LEN_W-1:0]     event_length,
  output logic [PAY_W-1:0]     event_payload,
  output logic                 last
);

  localparam int PTR_W = $clog2(RING_DEPTH);
  localparam int CNT_W = $clog2(RING_DEPTH + 1);
  localparam int AW    = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CALC  = 2'd1;
  localparam logic [1:0] ST_SETUP = 2'd2;
  localparam logic [1:0] ST_WALK  = 2'd3;

  logic [1:0]         state;
  logic [SEQ_W-1:0]   next_sequence;
  logic [PTR_W-1:0]   wr_ptr;
  logic [CNT_W-1:0]   fill_count;
  logic [SEQ_W-1:0]   start_r;
  logic [COUNT_W-1:0] maxc_r;
  logic [CNT_W-1:0]   avail_r;
  logic [PTR_W-1:0]   rd_idx;
  logic [COUNT_W-1:0] remain;
  logic               pend;
  logic               pend_last;

  logic               accept;
  logic               push;
  logic [LEN_W-1:0]   len_sat;
  logic [PAY_W-1:0]   pay_masked;
  entry_t             wr_entry;
  entry_t             rd_entry;
  logic               rd_en;
  logic               out_free;
  logic               land;
  logic               empty_load;

  logic [SEQ_W:0]     diff;
  logic               diff_hi_nz;
  logic [CNT_W-1:0]   avail_calc;
  logic [AW:0]        idx_diff;
  logic [PTR_W-1:0]   idx0;
  logic [COUNT_W-1:0] maxc_cap;
  logic [AW-1:0]      n_wide;
  logic [COUNT_W-1:0] n_calc;

  assign req_ready = (state == ST_IDLE);
  assign accept    = req_valid && req_ready;
  assign push      = accept && (op == OP_PUSH);
  assign out_free  = !rsp_valid || rsp_ready;

  // Saturate the length and zero bytes past it
  always_comb begin
    len_sat = (payload_length > RAW_LEN_W'(PAYLOAD_BYTES)) ?
              LEN_W'(PAYLOAD_BYTES) : payload_length[LEN_W-1:0];
    for (int b = 0; b < PAY_W / 8; b++) begin
      pay_masked[b*8 +: 8] = (LEN_W'(b) < len_sat) ? payload[b*8 +: 8] : 8'd0;
    end
    wr_entry.seq   = next_sequence;
    wr_entry.stamp = timestamp_ms;
    wr_entry.len   = len_sat;
    wr_entry.pay   = pay_masked;
  end

  // Clamp the start: count events from start to the head, at most the fill
  always_comb begin
    diff       = {1'b0, next_sequence} - {1'b0, start_r};
    diff_hi_nz = |diff[SEQ_W-1:CNT_W];
    if (diff[SEQ_W]) begin
      avail_calc = '0;
    end else if (diff_hi_nz || (diff[CNT_W-1:0] > fill_count)) begin
      avail_calc = fill_count;
    end else begin
      avail_calc = diff[CNT_W-1:0];
    end
  end

  // First slot and event count of the read
  always_comb begin
    idx_diff = (AW+1)'(wr_ptr) - (AW+1)'(avail_r);
    if (idx_diff[AW]) begin
      idx_diff = idx_diff + (AW+1)'(RING_DEPTH);
    end
    idx0     = idx_diff[PTR_W-1:0];
    maxc_cap = (maxc_r > MOST_RESULTS) ? MOST_RESULTS : maxc_r;
    n_wide   = (AW'(avail_r) < AW'(maxc_cap)) ? AW'(avail_r) : AW'(maxc_cap);
    n_calc   = n_wide[COUNT_W-1:0];
  end

  // Issue a read when the previous one can land this cycle or none is pending
  assign land       = pend && out_free;
  assign rd_en      = (state == ST_WALK) && (remain != '0) && (!pend || out_free);
  assign empty_load = (state == ST_SETUP) && (n_calc == '0) && out_free;

  sre_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (RING_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (push),
    .wr_addr (wr_ptr),
    .wr_data (wr_entry),
    .rd_en   (rd_en),
    .rd_addr (rd_idx),
    .rd_data (rd_entry)
  );

  // Sequence counter, write pointer and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      next_sequence <= '0;
      wr_ptr        <= '0;
      fill_count    <= '0;
    end else if (push) begin
      next_sequence <= next_sequence + 1'b1;
      if ((wr_ptr == PTR_W'(RING_DEPTH - 1)) || (&next_sequence)) begin
        wr_ptr <= '0;
      end else begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      // Treat the ring as empty again once the sequence wraps to zero
      if (&next_sequence) begin
        fill_count <= '0;
      end else if (fill_count != CNT_W'(RING_DEPTH)) begin
        fill_count <= fill_count + 1'b1;
      end
    end
  end

  // Read sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      remain    <= '0;
      pend      <= 1'b0;
      pend_last <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept && (op == OP_READ)) begin
            state <= ST_CALC;
          end
        end
        ST_CALC: begin
          state <= ST_SETUP;
        end
        ST_SETUP: begin
          if (n_calc != '0) begin
            remain <= n_calc;
            state  <= ST_WALK;
          end else if (out_free) begin
            state <= ST_IDLE;
          end
        end
        ST_WALK: begin
          if (rd_en) begin
            remain    <= remain - 1'b1;
            pend      <= 1'b1;
            pend_last <= (remain == COUNT_W'(1));
          end else if (land) begin
            pend <= 1'b0;
          end
          if ((remain == '0) && (!pend || out_free)) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Request and walk payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      start_r <= start_sequence;
      maxc_r  <= max_count;
    end
    if (state == ST_CALC) begin
      avail_r <= avail_calc;
    end
    if ((state == ST_SETUP) && (n_calc != '0)) begin
      rd_idx <= idx0;
    end else if (rd_en) begin
      rd_idx <= (rd_idx == PTR_W'(RING_DEPTH - 1)) ? '0 : rd_idx + 1'b1;
    end
  end

  // Output register: load a ring event or an empty marker, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (land || empty_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (land) begin
      valid_res      <= 1'b1;
      event_sequence <= rd_entry.seq;
      event_time     <= rd_entry.stamp;
      event_length   <= rd_entry.len;
      event_payload  <= rd_entry.pay;
      last           <= pend_last;
    end else if (empty_load) begin
      valid_res      <= 1'b0;
      event_sequence <= '0;
      event_time     <= '0;
      event_length   <= '0;
      event_payload  <= '0;
      last           <= 1'b1;
    end
  end

  // Checks
  a_idle_no_pending: assert property (@(posedge clk) disable iff (rst)
    req_ready |-> !pend)
    else $error("request taken while a ring read is still pending");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= CNT_W'(RING_DEPTH))
    else $error("fill level beyond ring depth");

  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    !(push && rd_en))
    else $error("push and ring walk in the same cycle");

  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !valid_res) |-> last)
    else $error("empty result not marked last");

endmodule

@@ rtl/sre_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// Used for the event ring storage. No dependencies.
module sre_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ verif/sequenced_event_ring_tb.sv @@
// Self-checking testbench for sequenced_event_ring: directed and random pushes and reads.
// A scoreboard class tracks the ring contents and queues the events each read should return.
// Depends on sre_pkg and the sequenced_event_ring RTL.
`timescale 1ns / 1ps

module sequenced_event_ring_tb;
  import sre_pkg::*;

  localparam int RING_DEPTH    = 16;
  localparam int PAYLOAD_BYTES = 8;
  localparam int STALL_LIMIT   = 2000;
  localparam int RANDOM_ITEMS  = 135;

  typedef struct {
    logic                 op;
    logic [PAY_W-1:0]     payload;
    logic [RAW_LEN_W-1:0] payload_length;
    logic [TIME_W-1:0]    timestamp_ms;
    logic [SEQ_W-1:0]     start_sequence;
    logic [COUNT_W-1:0]   max_count;
  } ring_request_t;

  typedef struct packed {
    logic              valid_res;
    logic [SEQ_W-1:0]  event_sequence;
    logic [TIME_W-1:0] event_time;
    logic [LEN_W-1:0]  event_length;
    logic [PAY_W-1:0]  event_payload;
    logic              last;
  } ring_result_t;

  // Mirror of the ring plus the events still owed to the result side
  class ring_scoreboard;
    logic [SEQ_W-1:0] next_seq;
    entry_t           ring[RING_DEPTH];
    ring_result_t     awaited_events[$];
    int unsigned      fails;

    function new();
      next_seq = '0;
      fails = 0;
    endfunction

    function int outstanding();
      return awaited_events.size();
    endfunction

    // Update the ring on a push, or queue the events a read returns
    function void take_request(ring_request_t r);
      logic [SEQ_W-1:0] oldest, first, avail, n;
      logic [LEN_W-1:0] len;
      logic [PAY_W-1:0] keep;
      int unsigned      idx;
      ring_result_t     res;
      if (r.op == OP_PUSH) begin
        len = (r.payload_length > PAYLOAD_BYTES) ? LEN_W'(PAYLOAD_BYTES)
                                                 : r.payload_length[LEN_W-1:0];
        keep = (len >= PAY_W / 8) ? {PAY_W{1'b1}} : ((64'd1 << (8 * len)) - 64'd1);
        idx = int'(next_seq % RING_DEPTH);
        ring[idx].seq   = next_seq;
        ring[idx].stamp = r.timestamp_ms;
        ring[idx].len   = len;
        ring[idx].pay   = r.payload & keep;
        next_seq = next_seq + 1;
      end else begin
        // Clamp an evicted start to the oldest stored event
        oldest = (next_seq >= RING_DEPTH) ? next_seq - RING_DEPTH : '0;
        first = (r.start_sequence < oldest) ? oldest : r.start_sequence;
        avail = (first < next_seq) ? next_seq - first : '0;
        n = avail;
        if (n > r.max_count) n = r.max_count;
        if (n > MOST_RESULTS) n = MOST_RESULTS;
        if (n == 0) begin
          res = '0;
          res.last = 1'b1;
          awaited_events.push_back(res);
        end
        for (int k = 0; k < n; k++) begin
          idx = int'((first + k) % RING_DEPTH);
          res.valid_res      = 1'b1;
          res.event_sequence = ring[idx].seq;
          res.event_time     = ring[idx].stamp;
          res.event_length   = ring[idx].len;
          res.event_payload  = ring[idx].pay;
          res.last           = (k + 1 == n);
          awaited_events.push_back(res);
        end
      end
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        fails++;
        $error("%s: expected %0h, got %0h", name, want, got);
      end
    endfunction

    // Match one delivered event against the oldest one owed
    function void check_event(ring_result_t got);
      ring_result_t want;
      if (awaited_events.size() == 0) begin
        fails++;
        $error("event_sequence: no result expected, got %0h", got.event_sequence);
        return;
      end
      want = awaited_events.pop_front();
      compare_field("valid_res", want.valid_res, got.valid_res);
      compare_field("event_sequence", want.event_sequence, got.event_sequence);
      compare_field("event_time", want.event_time, got.event_time);
      compare_field("event_length", want.event_length, got.event_length);
      compare_field("event_payload", want.event_payload, got.event_payload);
      compare_field("last", want.last, got.last);
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 req_valid = 1'b0;
  logic                 req_ready;
  logic                 op = OP_PUSH;
  logic [PAY_W-1:0]     payload = '0;
  logic [RAW_LEN_W-1:0] payload_length = '0;
  logic [TIME_W-1:0]    timestamp_ms = '0;
  logic [SEQ_W-1:0]     start_sequence = '0;
  logic [COUNT_W-1:0]   max_count = '0;
  logic                 rsp_valid;
  logic                 rsp_ready = 1'b0;
  logic                 valid_res;
  logic [SEQ_W-1:0]     event_sequence;
  logic [TIME_W-1:0]    event_time;
  logic [LEN_W-1:0]     event_length;
  logic [PAY_W-1:0]     event_payload;
  logic                 last;

  ring_scoreboard board;

  sequenced_event_ring #(
    .RING_DEPTH   (RING_DEPTH),
    .PAYLOAD_BYTES(PAYLOAD_BYTES)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_ready     (req_ready),
    .op            (op),
    .payload       (payload),
    .payload_length(payload_length),
    .timestamp_ms  (timestamp_ms),
    .start_sequence(start_sequence),
    .max_count     (max_count),
    .rsp_valid     (rsp_valid),
    .rsp_ready     (rsp_ready),
    .valid_res     (valid_res),
    .event_sequence(event_sequence),
    .event_time    (event_time),
    .event_length  (event_length),
    .event_payload (event_payload),
    .last          (last)
  );

  always #1 clk = ~clk;

  // Unused fields carry noise so every input bit toggles
  function automatic ring_request_t make_push(logic [PAY_W-1:0] pay,
                                              logic [RAW_LEN_W-1:0] len,
                                              logic [TIME_W-1:0] stamp);
    ring_request_t r;
    r.op             = OP_PUSH;
    r.payload        = pay;
    r.payload_length = len;
    r.timestamp_ms   = stamp;
    r.start_sequence = {$urandom, $urandom};
    r.max_count      = COUNT_W'($urandom);
    return r;
  endfunction

  function automatic ring_request_t make_read(logic [SEQ_W-1:0] start,
                                              logic [COUNT_W-1:0] count);
    ring_request_t r;
    r.op             = OP_READ;
    r.payload        = {$urandom, $urandom};
    r.payload_length = RAW_LEN_W'($urandom);
    r.timestamp_ms   = $urandom;
    r.start_sequence = start;
    r.max_count      = count;
    return r;
  endfunction

  // Present one request and hold it until the ring takes it
  task automatic send_request(ring_request_t r);
    req_valid      <= 1'b1;
    op             <= r.op;
    payload        <= r.payload;
    payload_length <= r.payload_length;
    timestamp_ms   <= r.timestamp_ms;
    start_sequence <= r.start_sequence;
    max_count      <= r.max_count;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    board.take_request(r);
  endtask

  // Receiver: always ready, a fixed stall pattern, or random stalls, by phase
  logic [15:0] stall_pattern = 16'b1110_1101_1111_0110;
  int unsigned ready_cycle = 0;

  always @(posedge clk) begin
    ready_cycle <= ready_cycle + 1;
    case ((ready_cycle / 97) % 3)
      0: rsp_ready <= 1'b1;
      1: rsp_ready <= stall_pattern[ready_cycle % 16];
      default: rsp_ready <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // Check every delivered event
  always @(posedge clk) begin
    ring_result_t seen;
    if (!rst && rsp_valid && rsp_ready) begin
      seen.valid_res      = valid_res;
      seen.event_sequence = event_sequence;
      seen.event_time     = event_time;
      seen.event_length   = event_length;
      seen.event_payload  = event_payload;
      seen.last           = last;
      board.check_event(seen);
    end
  end

  // Stop a hung run
  int unsigned quiet_cycles = 0;

  always @(posedge clk) begin
    if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    ring_request_t        r;
    int unsigned          burst_left, gap, back;
    logic [SEQ_W-1:0]     start;
    logic [COUNT_W-1:0]   count;
    logic [RAW_LEN_W-1:0] len;
    logic [TIME_W-1:0]    stamp;
    board = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Empty ring, then length saturation and masking of bytes past the length
    send_request(make_read(64'd0, 5'd16));
    send_request(make_push({PAY_W{1'b1}}, 8'd0, 32'd0));
    send_request(make_push({PAY_W{1'b1}}, 8'd8, 32'hFFFF_FFFF));
    send_request(make_push(64'h0123_4567_89AB_CDEF, 8'd255, 32'd1));
    send_request(make_push({PAY_W{1'b1}}, 8'd9, 32'd2));
    send_request(make_push(64'hA5A5_5A5A_F00F_0FF0, 8'd3, 32'd3));
    // Count above the limit, zero count, start past the end, start at the end
    send_request(make_read(64'd0, 5'd31));
    send_request(make_read(64'd0, 5'd0));
    send_request(make_read({SEQ_W{1'b1}}, 5'd16));
    send_request(make_read(64'd5, 5'd16));
    send_request(make_read(64'd2, 5'd2));
    // Wrap the ring so the oldest events are overwritten
    for (int i = 0; i < 12; i++)
      send_request(make_push({$urandom, $urandom}, 8'(i % 10), 32'(100 + i)));
    send_request(make_read(64'd0, 5'd16));
    send_request(make_read(64'd10, 5'd4));

    // Drain before the random part
    req_valid <= 1'b0;
    while (board.outstanding() != 0) @(posedge clk);
    @(posedge clk);

    burst_left = $urandom_range(1, 12);
    stamp = 32'd1000;
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      // Sender bursts with idle gaps between them
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap != 0) begin
          req_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      burst_left--;

      // Hold off now and then until every owed event has come back
      if (k % 60 == 59 && board.outstanding() != 0) begin
        req_valid <= 1'b0;
        while (board.outstanding() != 0) @(posedge clk);
      end

      if ($urandom_range(0, 99) < 55) begin
        len = ($urandom_range(0, 4) == 0) ? RAW_LEN_W'($urandom)
                                          : RAW_LEN_W'($urandom_range(0, PAYLOAD_BYTES));
        stamp = ($urandom_range(0, 7) == 0) ? $urandom : stamp + $urandom_range(0, 50);
        r = make_push({$urandom, $urandom}, len, stamp);
      end else begin
        back = $urandom_range(0, 20);
        case ($urandom_range(0, 5))
          0: start = '0;
          1: start = {$urandom, $urandom};
          2: start = board.next_seq + back;
          default: start = board.next_seq - back;
        endcase
        count = ($urandom_range(0, 5) == 0) ? COUNT_W'($urandom)
                                            : COUNT_W'($urandom_range(1, 16));
        r = make_read(start, count);
      end
      send_request(r);
    end

    // Wait out the remaining events, then watch for strays
    req_valid <= 1'b0;
    while (board.outstanding() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    if (board.fails == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/sre_pkg.sv
rtl/sre_ram.sv
rtl/sequenced_event_ring.sv
verif/sequenced_event_ring_tb.sv
